// ===== hw/rtl/hpdi_pkg.sv =====
// Shared constants, types and helper functions for the hash partition directory index.
// No dependencies; hpdi_mod and the top level refer to it by scoped names.
package hpdi_pkg;

    // Field widths
    localparam int SRV_W  = 16;
    localparam int HASH_W = 8;
    localparam int PIDX_W = 8;
    localparam int ACT_W  = 3;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 2;

    // Default geometry
    localparam int DEF_MAP_WORDS   = 8;
    localparam int DEF_WORD_BITS   = 32;
    localparam int DEF_RADIX_LIMIT = 8;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_LOOKUP  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SPLIT   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SET     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_MIGRATE = 3'd4;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ZEROTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_COUNT   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_POLICY  = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_BUCKETS = 2'd3;

    // Split policy codes
    localparam logic [1:0] POL_UNBOUNDED = 2'd0;
    localparam logic [1:0] POL_NEVER     = 2'd1;
    localparam logic [1:0] POL_BOUNDED   = 2'd2;
    localparam logic [1:0] POL_UNSPLIT   = 2'd3;

    // Status of the modulo unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_stat;

    // Number of significant bits of a value
    function automatic logic [4:0] f_bit_len(input logic [15:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) n = 5'(i + 1);
        end
        return n;
    endfunction

    // Mask that keeps the low n bits of a hash tail
    function automatic logic [HASH_W-1:0] f_low_mask(input logic [4:0] n);
        logic [HASH_W-1:0] m;
        if (n >= 5'(HASH_W)) m = '1;
        else m = (HASH_W'(1) << n) - HASH_W'(1);
        return m;
    endfunction

endpackage

// ===== hw/rtl/hpdi_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module hpdi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/hpdi_mod.sv =====
// Bit-serial restoring remainder unit: dividend mod divisor, one bit a cycle.
// Depends on hpdi_pkg for the server width and the status struct.
module hpdi_mod (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [hpdi_pkg::SRV_W:0] i_dividend,
    input  logic [hpdi_pkg::SRV_W-1:0] i_divisor,
    output hpdi_pkg::t_mod_stat      o_stat,
    output logic [hpdi_pkg::SRV_W-1:0] o_rem
);
    localparam int DW = hpdi_pkg::SRV_W + 1;
    localparam int CW = $clog2(DW + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DW-1:0]     r_num;
    logic [DW-2:0]     r_rem;
    logic [DW-2:0]     r_div;
    logic [DW-1:0]     trial;

    assign trial = {r_rem, r_num[DW-1]};

    // Shift in one dividend bit, subtract when it fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
                r_num  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                if (trial >= {1'b0, r_div}) r_rem <= (DW-1)'(trial - {1'b0, r_div});
                else r_rem <= trial[DW-2:0];
                r_num <= r_num << 1;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;
endmodule

// ===== hw/rtl/hash_partition_directory_index.sv =====
// Top level of the hash partition directory index: control sequencer around the bitmap RAM.
// Depends on hpdi_pkg, hpdi_ram and hpdi_mod.
//
// Usage: an item (action, hash tail, partition index) enters on i_valid/o_ready and
// one result item (partition, server, splittable, moves, error) leaves on
// o_valid/i_ready. Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data
// while no item is in flight. One item is worked on at a time; o_ready is high only
// while the sequencer is idle, and a finished result waits in the output register,
// so the next item is taken while the receiver stalls.
// Each bitmap test steps through address split, RAM read and check. A lookup walks one
// test per level (at most radix+1 levels), then runs the bit-serial modulo for the
// server number and issues the result. A split query tests the named partition and
// then each child candidate in turn (form it, test it); set and clear write the bitmap
// and then scan, stepping one word per cycle down the word-occupancy flags and then
// one bit per cycle down the highest occupied word to recompute the radix. A migration
// check goes straight to the result without a bitmap test.
// At reset the bitmap holds partition 0 only, the radix is one and the registers take
// their defaults; per-word valid bits stand in for the RAM contents, so no clearing
// pass is needed.
module hash_partition_directory_index #(
    parameter int MAP_WORDS   = hpdi_pkg::DEF_MAP_WORDS,
    parameter int WORD_BITS   = hpdi_pkg::DEF_WORD_BITS,
    parameter int RADIX_LIMIT = hpdi_pkg::DEF_RADIX_LIMIT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hpdi_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [hpdi_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [hpdi_pkg::ACT_W-1:0]    i_action,
    input  logic [hpdi_pkg::HASH_W-1:0]   i_hash_tail,
    input  logic [hpdi_pkg::PIDX_W-1:0]   i_partition_index,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [hpdi_pkg::PIDX_W-1:0]   o_partition,
    output logic [hpdi_pkg::SRV_W-1:0]    o_server,
    output logic                          o_splittable,
    output logic                          o_moves,
    output logic                          o_error
);
    localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW = $clog2(WORD_BITS);
    localparam int IW = ((RADIX_LIMIT > hpdi_pkg::PIDX_W) ? RADIX_LIMIT : hpdi_pkg::PIDX_W) + 1;
    localparam int MAP_BITS   = MAP_WORDS * WORD_BITS;
    localparam int INDEX_SPAN = (MAP_BITS < (2 ** RADIX_LIMIT)) ? MAP_BITS : (2 ** RADIX_LIMIT);
    localparam int SH    = 26;
    localparam int RECIP = ((2 ** SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int PW    = IW + 24;

    typedef struct packed {
        logic [hpdi_pkg::PIDX_W-1:0] part;
        logic [hpdi_pkg::SRV_W-1:0]  server;
        logic                        split;
        logic                        moves;
        logic                        err;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE, S_ADDR, S_RD, S_CHK, S_SPK, S_WSCAN, S_WGET, S_BSCAN, S_MOD, S_OUT
    } t_state;

    t_state                      r_state;
    logic [hpdi_pkg::SRV_W-1:0]  r_zeroth;
    logic [hpdi_pkg::SRV_W-1:0]  r_count;
    logic [1:0]                  r_policy;
    logic [8:0]                  r_buckets;
    logic [3:0]                  r_radix;
    logic [hpdi_pkg::ACT_W-1:0]  r_action;
    logic [IW-1:0]               r_idx;
    logic [hpdi_pkg::PIDX_W-1:0] r_base;
    logic [3:0]                  r_k;
    logic                        r_phase;
    logic                        r_ivld;
    logic [PW-1:0]               r_prod;
    logic [BW-1:0]               r_bit;
    logic [AW-1:0]               r_rword;
    logic [AW-1:0]               r_w;
    logic [BW-1:0]               r_b;
    logic [WORD_BITS-1:0]        r_data;
    logic [MAP_WORDS-1:0]        r_wvalid;
    logic [MAP_WORDS-1:0]        r_nz;
    t_result                     r_res;
    t_result                     r_out;
    logic                        r_ovalid;

    logic [IW-1:0]               quot;
    logic [AW-1:0]               ram_raddr;
    logic                        ram_we;
    logic [WORD_BITS-1:0]        ram_wdata;
    logic [WORD_BITS-1:0]        ram_q;
    logic [WORD_BITS-1:0]        word;
    logic                        present;
    logic [hpdi_pkg::SRV_W-1:0]  count_eff;
    logic [24:0]                 bound;
    logic                        split_ok;
    logic [IW-1:0]               child;
    logic [4:0]                  idx_len;
    logic [4:0]                  pidx_len;
    logic [15:0]                 high;
    logic [4:0]                  high_len;
    logic                        pidx_ok;
    t_result                     n_res;
    logic                        mod_start;
    hpdi_pkg::t_mod_stat         mod_stat;
    logic [hpdi_pkg::SRV_W-1:0]  mod_rem;

    // Bitmap storage
    hpdi_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_rword),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // Server number modulo the server count
    hpdi_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend ((hpdi_pkg::SRV_W + 1)'(r_idx[hpdi_pkg::PIDX_W-1:0])
                     + (hpdi_pkg::SRV_W + 1)'(r_zeroth)),
        .i_divisor  (count_eff),
        .o_stat     (mod_stat),
        .o_rem      (mod_rem)
    );

    // Word and bit of the index under test, read address, presence
    always_comb begin
        quot      = IW'(r_prod >> SH);
        ram_raddr = '0;
        if (r_state == S_RD && r_ivld) ram_raddr = quot[AW-1:0];
        else if (r_state == S_WSCAN) ram_raddr = r_w;

        if (r_wvalid[r_rword]) word = ram_q;
        else if (r_rword == '0) word = WORD_BITS'(1);
        else word = '0;
        present = r_ivld && word[r_bit];

        ram_we    = (r_state == S_CHK)
                    && (r_action == hpdi_pkg::ACT_SET || r_action == hpdi_pkg::ACT_CLEAR);
        if (r_action == hpdi_pkg::ACT_SET) ram_wdata = word | (WORD_BITS'(1) << r_bit);
        else ram_wdata = word & ~(WORD_BITS'(1) << r_bit);

        count_eff = (r_count == '0) ? hpdi_pkg::SRV_W'(1) : r_count;
        bound     = 25'(r_buckets) * 25'(count_eff);
        case (r_policy)
            hpdi_pkg::POL_UNBOUNDED: split_ok = 1'b1;
            hpdi_pkg::POL_BOUNDED:   split_ok = 25'(r_idx) < bound;
            default:                 split_ok = 1'b0;
        endcase

        child    = IW'(r_base) + (IW'(1) << r_k);
        idx_len  = hpdi_pkg::f_bit_len(16'(r_idx));
        pidx_len = hpdi_pkg::f_bit_len(16'(i_partition_index));
        high     = 16'(32'(r_w) * WORD_BITS + 32'(r_b));
        high_len = hpdi_pkg::f_bit_len(high);
        mod_start = (r_state == S_CHK) && (r_action == hpdi_pkg::ACT_LOOKUP) && present;

        // Result fields known as soon as an item arrives
        pidx_ok = 32'(i_partition_index) < INDEX_SPAN;
        n_res   = '0;
        case (i_action)
            hpdi_pkg::ACT_LOOKUP: ;
            hpdi_pkg::ACT_SPLIT:  ;
            hpdi_pkg::ACT_SET:    n_res.err = !pidx_ok;
            hpdi_pkg::ACT_CLEAR:  n_res.err = (i_partition_index == '0) || !pidx_ok;
            hpdi_pkg::ACT_MIGRATE: begin
                if (pidx_ok)
                    n_res.moves = (i_hash_tail & hpdi_pkg::f_low_mask(pidx_len))
                                  == i_partition_index;
                else n_res.err = 1'b1;
            end
            default: n_res.err = 1'b1;
        endcase
    end

    // Sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        r_rword <= ram_raddr;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_zeroth  <= '0;
            r_count   <= hpdi_pkg::SRV_W'(1);
            r_policy  <= hpdi_pkg::POL_UNBOUNDED;
            r_buckets <= 9'd1;
            r_radix   <= 4'd1;
            r_wvalid  <= '0;
            r_nz      <= MAP_WORDS'(1);
            r_ovalid  <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && r_state != S_OUT) r_ovalid <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    hpdi_pkg::CFG_ZEROTH:  r_zeroth  <= i_cfg_data;
                    hpdi_pkg::CFG_COUNT:   r_count   <= i_cfg_data;
                    hpdi_pkg::CFG_POLICY:  r_policy  <= i_cfg_data[1:0];
                    hpdi_pkg::CFG_BUCKETS: r_buckets <= i_cfg_data[8:0];
                    default: ;
                endcase
            end

            case (r_state)
                // Take an item and route it by action
                S_IDLE: begin
                    if (i_valid) begin
                        r_action <= i_action;
                        r_res    <= n_res;
                        r_phase  <= 1'b0;
                        if (i_action == hpdi_pkg::ACT_LOOKUP)
                            r_idx <= IW'(i_hash_tail & hpdi_pkg::f_low_mask(5'(r_radix)));
                        else r_idx <= IW'(i_partition_index);
                        if (n_res.err || i_action == hpdi_pkg::ACT_MIGRATE) r_state <= S_OUT;
                        else r_state <= S_ADDR;
                    end
                end
                // Split the index into word and bit
                S_ADDR: begin
                    r_prod  <= PW'(r_idx) * PW'(RECIP);
                    r_ivld  <= 32'(r_idx) < INDEX_SPAN;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_bit   <= BW'(r_idx - IW'(quot * IW'(WORD_BITS)));
                    r_state <= S_CHK;
                end
                // Act on the presence of the tested partition, or write the bitmap for set and clear
                S_CHK: begin
                    case (r_action)
                        hpdi_pkg::ACT_LOOKUP: begin
                            if (present) begin
                                r_res.part <= r_idx[hpdi_pkg::PIDX_W-1:0];
                                r_state    <= S_MOD;
                            end else begin
                                r_idx   <= r_idx & ~(IW'(1) << (idx_len - 5'd1));
                                r_state <= S_ADDR;
                            end
                        end
                        hpdi_pkg::ACT_SPLIT: begin
                            if (!r_phase) begin
                                if (present) begin
                                    r_base  <= r_idx[hpdi_pkg::PIDX_W-1:0];
                                    r_k     <= idx_len[3:0];
                                    r_state <= S_SPK;
                                end else begin
                                    r_res.err <= 1'b1;
                                    r_state   <= S_OUT;
                                end
                            end else if (!present) begin
                                r_res   <= '{part: r_idx[hpdi_pkg::PIDX_W-1:0],
                                             split: split_ok, default: '0};
                                r_state <= S_OUT;
                            end else begin
                                r_k     <= r_k + 4'd1;
                                r_state <= S_SPK;
                            end
                        end
                        default: begin
                            r_wvalid[r_rword] <= 1'b1;
                            r_nz[r_rword]     <= |ram_wdata;
                            r_w               <= AW'(MAP_WORDS - 1);
                            r_state           <= S_WSCAN;
                        end
                    endcase
                end
                // Next child candidate of a split
                S_SPK: begin
                    if (32'(r_k) >= RADIX_LIMIT || 32'(child) >= INDEX_SPAN) begin
                        r_res.err <= 1'b1;
                        r_state   <= S_OUT;
                    end else begin
                        r_idx   <= child;
                        r_phase <= 1'b1;
                        r_state <= S_ADDR;
                    end
                end
                // Find the highest occupied word
                S_WSCAN: begin
                    if (r_nz[r_w]) r_state <= S_WGET;
                    else r_w <= r_w - AW'(1);
                end
                S_WGET: begin
                    r_data  <= word;
                    r_b     <= BW'(WORD_BITS - 1);
                    r_state <= S_BSCAN;
                end
                // Find the highest set bit in that word
                S_BSCAN: begin
                    if (r_data[r_b]) begin
                        r_radix <= high_len[3:0];
                        r_state <= S_OUT;
                    end else r_b <= r_b - BW'(1);
                end
                S_MOD: begin
                    if (mod_stat.done) begin
                        r_res.server <= mod_rem;
                        r_state      <= S_OUT;
                    end
                end
                // Hand the result to the output register
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_out    <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_partition  = r_out.part;
    assign o_server     = r_out.server;
    assign o_splittable = r_out.split;
    assign o_moves      = r_out.moves;
    assign o_error      = r_out.err;

    // Checks on the sequencer
    a_mod_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mod_stat.busy) else $error("modulo unit busy while idle");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready) else $error("second item taken during work");
    a_mod_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_stat.done |-> (r_state == S_MOD)) else $error("modulo result outside wait");
    a_write_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_state == S_WSCAN)) else $error("bitmap write without radix scan");
endmodule
